@@ design/tlbe_pkg.sv @@
// Shared types for the terminated line buffer echo block.
// Beat payload structs and the per-item flag bundle; no dependencies.
package tlbe_pkg;

    localparam logic [7:0] TERMINATOR_RESET = 8'd13;

    // Configuration register indexes (word addresses)
    localparam logic [1:0] REG_TERMINATOR = 2'd0;

    // Item operation codes
    localparam logic OP_RX_BYTE  = 1'b0;
    localparam logic OP_TX_READY = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       line_done;
        logic [6:0] line_length;
        logic       overflow;
        logic       busy_res;
    } result_t;

    // Result fields known at accept time; tx_byte follows from the store read
    typedef struct packed {
        logic       tx_valid;
        logic       line_done;
        logic [6:0] line_length;
        logic       overflow;
        logic       busy_res;
    } flags_t;

endpackage

@@ design/terminated_line_buffer_echo.sv @@
// Top level of the terminated line buffer echo block.
// Depends on tlbe_pkg, tlbe_ctrl and tlbe_line_mem.
//
// Usage:
//   item channel (item_valid/item_ready/item): one beat per event, either a
//   received byte (operation 0) or a transmitter-ready event (operation 1).
//   result channel (result_valid/result_ready/result): exactly one beat per
//   item, in order. A line that ends in the terminator byte is reported on
//   the beat of its last byte and then echoed one byte per ready event.
//   APB port: one register at word 0, the terminator byte (reset 13).
// Pipeline: a taken item's flags wait in the read stage while the line store
//   read completes; the result beat then moves through the output register.
// Throughput: one item per cycle while result_ready is high; the store has separate write and
//   read ports, so a byte write and an echo read never contend.
// Reset: pointers clear, no line is being sent; the store is not cleared,
//   since only written entries are ever read back.
// Stall: while result_ready is low a full output register holds, and so does
//   the read stage; item_ready drops once both are full and rises with the next beat.
module terminated_line_buffer_echo
    import tlbe_pkg::*;
#(
    parameter int LINE_CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH  = 2 * LINE_CAPACITY;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(LINE_CAPACITY);

    logic              accept;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    flags_t            flags;

    // read stage: flags wait here while the store read completes
    logic    s1_valid_reg, s1_valid_next;
    flags_t  s1_flags_reg;
    logic    s1_move;
    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    logic    out_free;
    logic [7:0] terminator_reg;

    // ---------------- configuration ----------------
    // single register: every word offset decodes to it
    assign pready = 1'b1;
    assign prdata = {24'd0, terminator_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg <= TERMINATOR_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            terminator_reg <= pwdata[7:0];
        end
    end

    // ---------------- handshake ----------------
    assign out_free   = !out_valid_reg || result_ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_ready = !s1_valid_reg || out_free;
    assign accept     = item_valid && item_ready;

    tlbe_ctrl #(
        .CAP    (LINE_CAPACITY),
        .POS_W  (POS_W),
        .ADDR_W (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .terminator (terminator_reg),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .flags      (flags)
    );

    // read data only changes on a new read, so it holds while s1 stalls
    tlbe_line_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
        end
        if (s1_move)
        begin
            out_reg.tx_valid    <= s1_flags_reg.tx_valid;
            out_reg.tx_byte     <= s1_flags_reg.tx_valid ? mem_rdata : 8'd0;
            out_reg.line_done   <= s1_flags_reg.line_done;
            out_reg.line_length <= s1_flags_reg.line_length;
            out_reg.overflow    <= s1_flags_reg.overflow;
            out_reg.busy_res    <= s1_flags_reg.busy_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // a held read-stage beat keeps its store data until it moves on
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(mem_rdata))
        else $error("read stage lost its data while stalled");

    // items are refused only while both stages are occupied and blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> s1_valid_reg && out_valid_reg && !result_ready)
        else $error("item refused with room in the pipeline");

    // a beat never reports a sent byte and a line event at once
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tx_valid |-> !result.line_done && !result.overflow)
        else $error("echo byte and line event on one beat");

    // an echo read is issued only for a ready event that was taken
    a_read_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> accept && item.operation == OP_TX_READY)
        else $error("store read without a ready event");
`endif

endmodule

@@ design/tlbe_line_mem.sv @@
// Two-half line store: one write port, one read port, registered read data.
// Depends on nothing; read data holds while no read is issued.
module tlbe_line_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/tlbe_ctrl.sv @@
// Fill/send pointer state and per-item decisions; issues store accesses.
// Depends on tlbe_pkg.
module tlbe_ctrl
    import tlbe_pkg::*;
#(
    parameter int CAP    = 128,
    parameter int POS_W  = 7,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  item_t             item,
    input  logic [7:0]        terminator,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    output flags_t            flags
);

    localparam logic [POS_W-1:0]  FILL_LIMIT = POS_W'(CAP - 1);
    localparam logic [ADDR_W-1:0] HALF_BASE  = ADDR_W'(CAP);

    logic             fill_half_reg, fill_half_next;
    logic [POS_W-1:0] fill_pos_reg, fill_pos_next;
    logic             send_half_reg, send_half_next;
    logic [POS_W-1:0] send_pos_reg, send_pos_next;
    logic [POS_W-1:0] send_count_reg, send_count_next;
    logic             sending_reg, sending_next;
    logic [POS_W-1:0] fill_inc;

    assign fill_inc  = fill_pos_reg + POS_W'(1);
    assign mem_wdata = item.rx_byte;
    assign mem_waddr = (fill_half_reg ? HALF_BASE : '0) + ADDR_W'(fill_pos_reg);
    assign mem_raddr = (send_half_reg ? HALF_BASE : '0) + ADDR_W'(send_pos_reg);

    always_comb
    begin
        fill_half_next  = fill_half_reg;
        fill_pos_next   = fill_pos_reg;
        send_half_next  = send_half_reg;
        send_pos_next   = send_pos_reg;
        send_count_next = send_count_reg;
        sending_next    = sending_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        flags           = '0;
        if (accept)
        begin
            if (item.operation == OP_RX_BYTE)
            begin
                if (fill_pos_reg < FILL_LIMIT)
                begin
                    mem_we        = 1'b1;
                    fill_pos_next = fill_inc;
                    if (item.rx_byte == terminator)
                    begin
                        flags.line_done   = 1'b1;
                        flags.line_length = 7'(fill_inc);
                        send_half_next    = fill_half_reg;
                        send_count_next   = fill_inc;
                        send_pos_next     = '0;
                        sending_next      = 1'b1;
                        fill_half_next    = ~fill_half_reg;
                        fill_pos_next     = '0;
                    end
                end
                else
                begin
                    fill_pos_next  = '0;
                    flags.overflow = 1'b1;
                end
            end
            else if (sending_reg)
            begin
                if (send_pos_reg < send_count_reg)
                begin
                    mem_re         = 1'b1;
                    flags.tx_valid = 1'b1;
                    send_pos_next  = send_pos_reg + POS_W'(1);
                end
                else
                begin
                    sending_next = 1'b0;
                end
            end
        end
        flags.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_half_reg  <= 1'b0;
            fill_pos_reg   <= '0;
            send_half_reg  <= 1'b0;
            send_pos_reg   <= '0;
            send_count_reg <= '0;
            sending_reg    <= 1'b0;
        end
        else
        begin
            fill_half_reg  <= fill_half_next;
            fill_pos_reg   <= fill_pos_next;
            send_half_reg  <= send_half_next;
            send_pos_reg   <= send_pos_next;
            send_count_reg <= send_count_next;
            sending_reg    <= sending_next;
        end
    end

endmodule

@@ tb/terminated_line_buffer_echo_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for terminated_line_buffer_echo: watches item, result and APB traffic.
// Keeps its own line store model; depends on tlbe_pkg only.
module terminated_line_buffer_echo_checker
    import tlbe_pkg::*;
#(
    parameter int LINE_CAPACITY = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_beats
);

    localparam logic [1:0] TERM_ADDR = 2'(4 * int'(REG_TERMINATOR));
    localparam int         PRINT_CAP = 100;

    // model of the two-half store and its pointers
    logic [7:0] line_copy [0:2*LINE_CAPACITY-1];
    logic       fill_half;
    int         fill_pos;
    logic       send_half;
    int         send_pos;
    int         send_count;
    logic       sending;
    logic [7:0] terminator;

    result_t    expected_beats [$];
    int         mismatches = 0;
    int         waiting = 0;

    assign error_count   = mismatches;
    assign pending_beats = waiting;

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // advances the model by one beat and returns the beat the block must answer
    function automatic result_t predict_echo(input item_t it);
        result_t r;
        r = '0;
        if (it.operation == OP_RX_BYTE) begin
            if (fill_pos < LINE_CAPACITY - 1) begin
                line_copy[int'(fill_half) * LINE_CAPACITY + fill_pos] = it.rx_byte;
                fill_pos++;
                if (it.rx_byte == terminator) begin
                    r.line_done   = 1'b1;
                    r.line_length = 7'(fill_pos);
                    send_half     = fill_half;
                    send_count    = fill_pos;
                    send_pos      = 0;
                    sending       = 1'b1;
                    fill_half     = ~fill_half;
                    fill_pos      = 0;
                end
            end
            else
            begin
                // fill limit: byte dropped, even a terminator
                fill_pos   = 0;
                r.overflow = 1'b1;
            end
        end
        else if (sending) begin
            if (send_pos < send_count) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = line_copy[int'(send_half) * LINE_CAPACITY + send_pos];
                send_pos++;
            end
            else
            begin
                sending = 1'b0;
            end
        end
        r.busy_res = sending;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            fill_half  = 1'b0;
            fill_pos   = 0;
            send_half  = 1'b0;
            send_pos   = 0;
            send_count = 0;
            sending    = 1'b0;
            terminator = TERMINATOR_RESET;
            expected_beats.delete();
            waiting = 0;
        end
        else
        begin
            // compare first, so a result can never match an item taken on the same edge
            if (result_valid && result_ready) begin
                if (expected_beats.size() == 0) begin
                    report($sformatf("result beat %h with nothing expected", result));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.tx_valid !== want.tx_valid)
                        report($sformatf("tx_valid %b, expected %b",
                                         result.tx_valid, want.tx_valid));
                    if (result.tx_byte !== want.tx_byte)
                        report($sformatf("tx_byte %h, expected %h",
                                         result.tx_byte, want.tx_byte));
                    if (result.line_done !== want.line_done)
                        report($sformatf("line_done %b, expected %b",
                                         result.line_done, want.line_done));
                    if (result.line_length !== want.line_length)
                        report($sformatf("line_length %0d, expected %0d",
                                         result.line_length, want.line_length));
                    if (result.overflow !== want.overflow)
                        report($sformatf("overflow %b, expected %b",
                                         result.overflow, want.overflow));
                    if (result.busy_res !== want.busy_res)
                        report($sformatf("busy_res %b, expected %b",
                                         result.busy_res, want.busy_res));
                end
            end
            if (item_valid && item_ready)
                expected_beats.push_back(predict_echo(item));
            if (psel && penable && pready && paddr == TERM_ADDR) begin
                if (pwrite)
                    terminator = pwdata[7:0];
                else if (prdata !== {24'd0, terminator})
                    report($sformatf("terminator read %h, expected %h", prdata, terminator));
            end
            waiting = expected_beats.size();
        end
    end

endmodule

@@ tb/terminated_line_buffer_echo_tb.sv @@
`timescale 1ns / 1ps
// Top of the terminated_line_buffer_echo testbench: clock, reset, stimulus, verdict.
// Depends on tlbe_pkg, the block and terminated_line_buffer_echo_checker.
module terminated_line_buffer_echo_tb
    import tlbe_pkg::*;
();

    localparam int         LINE_CAPACITY = 128;
    localparam logic [1:0] TERM_ADDR     = 2'(4 * int'(REG_TERMINATOR));
    localparam int         HOLDOFF_LEN   = 300;     // long receiver hold-off, cycles
    localparam int         MAX_GAP       = 20;      // cap on one sender gap
    localparam int         TAIL_CYCLES   = 10;      // quiet tail after the drain, be generous
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PHASE_ITEMS   = 305;

    // every block input starts at a known value
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [1:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    int          err_count;
    int          pending;

    // idling knobs, in percent; written only by the main sequence
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    // hold-off handshake: main sequence bumps the request, receiver serves it
    int          holdoff_asked  = 0;
    int          holdoff_served = 0;
    int          holdoff_left   = 0;

    int          items_sent     = 0;
    int          cycle_count    = 0;
    logic [7:0]  term_now       = TERMINATOR_RESET;   // terminator the stimulus aims at

    terminated_line_buffer_echo #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    terminated_line_buffer_echo_checker #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .error_count   (err_count),
        .pending_beats (pending)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver side. A hold-off request forces ready low until a HOLDOFF_LEN countdown
    // runs out, so the block fills and has to push back on the item channel; otherwise
    // ready drops at random per the current stall percentage.
    always @(posedge clk)
    begin
        if (holdoff_asked != holdoff_served)
        begin
            holdoff_served = holdoff_asked;
            holdoff_left   = HOLDOFF_LEN;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // One beat on the item channel. Valid is only lowered when a gap is drawn,
    // so back-to-back beats keep it high with a single assignment per edge.
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(item_t'{operation: OP_RX_BYTE, rx_byte: b});
    endtask

    // ready events carry a junk byte; the block must ignore it
    task automatic send_readies(input int n);
        repeat (n) send_item(item_t'{operation: OP_TX_READY, rx_byte: 8'($urandom)});
    endtask

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == term_now)
            b = 8'($urandom);
        return b;
    endfunction

    // n bytes that never end a line
    task automatic send_plain(input int n);
        repeat (n) send_rx(other_byte());
    endtask

    // sender goes quiet until every result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= TERM_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register changes only with the block empty; write, idle, read back
    task automatic set_terminator(input logic [7:0] t);
        drain_results();
        repeat (4) @(posedge clk);
        apb_access(1'b1, {24'd0, t});
        @(posedge clk);
        apb_access(1'b0, '0);
        term_now = t;
    endtask

    // Random traffic. Mostly complete lines (short, now and then long) followed
    // by some ready events to echo them; a few fill-limit runs around the
    // capacity, partial lines left open, and raw noise on both operations.
    task automatic run_random(input int count);
        int stop;
        int kind;
        int len;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, LINE_CAPACITY - 1)
                                                   : $urandom_range(1, 12);
                send_plain(len - 1);
                send_rx(term_now);
                send_readies($urandom_range(0, len + 2));
            end
            else if (kind < 63)
            begin
                // 126 gives the longest line, 127 drops the terminator itself
                send_plain($urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY));
                send_rx(term_now);
            end
            else if (kind < 75)
            begin
                send_plain($urandom_range(1, 8));
            end
            else
            begin
                repeat ($urandom_range(1, 6)) send_item(item_t'(9'($urandom)));
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of the register
        apb_access(1'b0, '0);

        // Directed, reset terminator (carriage return)
        send_readies(1);                        // ready while idle
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(8'h55);
        send_rx(8'hAA);
        send_rx(term_now);                      // five-byte line
        send_readies(6);                        // all five out, then end of line
        send_readies(1);                        // idle again
        send_rx(8'h78);
        send_rx(term_now);
        send_readies(1);
        send_rx(8'h79);
        send_rx(8'h7A);
        send_rx(term_now);                      // new line while sending
        send_readies(4);

        // Phase A: terminator all ones, no idling, long receiver hold-off
        set_terminator(8'hFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_asked++;
        run_random(40);
        // longest line, then terminator landing on the fill limit
        send_plain(LINE_CAPACITY - 2);
        send_rx(term_now);
        send_readies(3);
        send_plain(LINE_CAPACITY - 1);
        send_rx(term_now);
        run_random(PHASE_ITEMS - 300);

        // Phase B: terminator zero, sparse sender, one full drain midway
        set_terminator(8'h00);
        send_idle_pct = 75;
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS / 2);

        // Phase C: carriage return again, receiver stalling
        set_terminator(TERMINATOR_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        run_random(PHASE_ITEMS);

        // Phase D: random terminator, both sides idling
        set_terminator(8'($urandom));
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(PHASE_ITEMS);

        // Phase E: line feed, no idling
        set_terminator(8'h0A);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(PHASE_ITEMS);

        // Phase F: random terminator, both idling
        set_terminator(8'($urandom));
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        run_random(PHASE_ITEMS);

        // wrap up: everything back, then a quiet tail for strays
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
design/tlbe_pkg.sv
design/tlbe_line_mem.sv
design/tlbe_ctrl.sv
design/terminated_line_buffer_echo.sv
tb/terminated_line_buffer_echo_checker.sv
tb/terminated_line_buffer_echo_tb.sv
